// ===== rtl/lsc_pkg.sv =====
// Shared types and constants for the line segment clipper.
// Holds the coordinate, ratio and divider lane types and the register indexes.
// No dependencies.
`default_nettype none

package lsc_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int T_FRAC_BITS     = 16;
    localparam int DIV_STAGES      = 4;
    localparam int DIV_STEPS       = (T_FRAC_BITS + DIV_STAGES - 1) / DIV_STAGES;
    localparam int DELTA_WIDTH     = COORD_WIDTH + 1;
    localparam int RATIO_WIDTH     = T_FRAC_BITS + 3;
    localparam int T_WIDTH         = T_FRAC_BITS + 1;
    localparam int CFG_INDEX_WIDTH = 4;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DELTA_WIDTH-1:0] delta_t;
    typedef logic signed [RATIO_WIDTH-1:0] ratio_t;
    typedef logic        [T_WIDTH-1:0]     tval_t;
    typedef logic        [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_CLIP_LEFT   = cfg_index_t'(0);
    localparam cfg_index_t REG_CLIP_RIGHT  = cfg_index_t'(1);
    localparam cfg_index_t REG_CLIP_BOTTOM = cfg_index_t'(2);
    localparam cfg_index_t REG_CLIP_TOP    = cfg_index_t'(3);

    localparam ratio_t T_ONE = ratio_t'({1'b1, {T_FRAC_BITS{1'b0}}});

    // One ratio in flight: partial remainder, fraction bits so far and the
    // flags that settle the integer part, saturation and sign.
    typedef struct packed {
        logic [COORD_WIDTH-1:0] rem;
        logic [T_FRAC_BITS-1:0] frac;
        logic [COORD_WIDTH-1:0] mp;
        logic                   ip;
        logic                   sat;
        logic                   neg;
    } div_lane_t;

endpackage

`default_nettype wire

// ===== rtl/lsc_divider.sv =====
// Pipelined restoring divider for one edge ratio q/p in fixed point.
// Depends on lsc_pkg.
`default_nettype none

module lsc_divider (
    input  wire                 aclk,
    input  wire                 en,
    input  lsc_pkg::div_lane_t  lane_in,
    output lsc_pkg::ratio_t     ratio
);
    import lsc_pkg::*;

    div_lane_t stage_src  [DIV_STAGES];
    div_lane_t stage_next [DIV_STAGES];
    div_lane_t stage_reg  [DIV_STAGES];
    div_lane_t last;
    logic [T_FRAC_BITS+1:0] mag;

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_stage
            if (g == 0) begin : g_first
                assign stage_src[g] = lane_in;
            end else begin : g_rest
                assign stage_src[g] = stage_reg[g-1];
            end

            always_comb begin
                logic [COORD_WIDTH:0] sh;
                stage_next[g] = stage_src[g];
                for (int k = 0; k < DIV_STEPS; k++) begin
                    if (g * DIV_STEPS + k < T_FRAC_BITS) begin
                        sh = {stage_next[g].rem, 1'b0};
                        if (sh >= {1'b0, stage_next[g].mp}) begin
                            stage_next[g].rem  = COORD_WIDTH'(sh - {1'b0, stage_next[g].mp});
                            stage_next[g].frac = {stage_next[g].frac[T_FRAC_BITS-2:0], 1'b1};
                        end else begin
                            stage_next[g].rem  = sh[COORD_WIDTH-1:0];
                            stage_next[g].frac = {stage_next[g].frac[T_FRAC_BITS-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    stage_reg[g] <= stage_next[g];
                end
            end
        end
    endgenerate

    assign last = stage_reg[DIV_STAGES-1];

    // A ratio of two or more saturates; every comparison still comes out the same.
    always_comb begin
        if (last.sat) begin
            mag = {2'b10, {T_FRAC_BITS{1'b0}}};
        end else begin
            mag = {1'b0, last.ip, last.frac};
        end
        if (last.neg) begin
            ratio = -ratio_t'(mag);
        end else begin
            ratio = ratio_t'(mag);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lsc_interp.sv =====
// Interpolation of one clipped coordinate with a registered product: a + t*d, truncated toward zero.
// Depends on lsc_pkg.
`default_nettype none

module lsc_interp (
    input  wire              aclk,
    input  wire              en,
    input  lsc_pkg::coord_t  a,
    input  lsc_pkg::tval_t   t,
    input  lsc_pkg::delta_t  d,
    output lsc_pkg::coord_t  result
);
    import lsc_pkg::*;

    localparam int PW = T_WIDTH + COORD_WIDTH;

    logic [COORD_WIDTH-1:0] dmag;
    logic [PW-1:0]          prod_next;
    logic [PW-1:0]          prod_reg;
    coord_t                 a_reg;
    logic                   dneg_reg;
    logic [COORD_WIDTH-1:0] ipart;
    logic                   frac_nz;
    logic [COORD_WIDTH+1:0] base;
    logic [COORD_WIDTH+1:0] base_adj;

    always_comb begin
        if (d[DELTA_WIDTH-1]) begin
            dmag = COORD_WIDTH'(-d);
        end else begin
            dmag = COORD_WIDTH'(d);
        end
        prod_next = {{COORD_WIDTH{1'b0}}, t} * {{T_WIDTH{1'b0}}, dmag};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            a_reg    <= a;
            dneg_reg <= d[DELTA_WIDTH-1];
        end
    end

    assign ipart   = prod_reg[T_FRAC_BITS +: COORD_WIDTH];
    assign frac_nz = |prod_reg[T_FRAC_BITS-1:0];

    // A dropped fraction pulls the sum one step back toward zero.
    always_comb begin
        if (dneg_reg) begin
            base = {{2{a_reg[COORD_WIDTH-1]}}, a_reg} - {2'b00, ipart};
        end else begin
            base = {{2{a_reg[COORD_WIDTH-1]}}, a_reg} + {2'b00, ipart};
        end
        base_adj = base;
        if (frac_nz) begin
            if (!dneg_reg && base[COORD_WIDTH+1]) begin
                base_adj = base + 1'b1;
            end else if (dneg_reg && !base[COORD_WIDTH+1] && (base != '0)) begin
                base_adj = base - 1'b1;
            end
        end
    end

    assign result = base_adj[COORD_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== rtl/line_segment_clipper_core.sv =====
// Liang-Barsky line segment clipper, top level.
// Uses lsc_pkg, lsc_divider and lsc_interp.
//
// Usage: a segment enters on the s_ channel as four signed endpoint coordinates,
// and one beat leaves on the m_ channel with the visible flag and the clipped
// endpoints (the input endpoints again when the segment is rejected). The window
// sits in four registers written through the cfg_ channel, index 0 to 3 for
// left, right, bottom and top; other indexes are ignored. cfg_ready is always
// high, and the window must only be changed while no segment is in flight.
// Each segment passes through one front stage, four divider stages (four quotient
// bits each), the edge test stages e1 and e2, the multiplier stage and the output register.
// One segment can enter every cycle while s_ready is high.
// The pipeline moves as a whole: when the receiver holds m_ready low with a beat
// waiting, every stage holds and s_ready drops in the same cycle.
// Reset empties the pipeline and loads the window with left 0, right 32767,
// bottom 0 and top 32767.
`default_nettype none

module line_segment_clipper_core (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  lsc_pkg::coord_t         s_start_x,
    input  lsc_pkg::coord_t         s_start_y,
    input  lsc_pkg::coord_t         s_end_x,
    input  lsc_pkg::coord_t         s_end_y,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic                    m_visible,
    output lsc_pkg::coord_t         m_clipped_start_x,
    output lsc_pkg::coord_t         m_clipped_start_y,
    output lsc_pkg::coord_t         m_clipped_end_x,
    output lsc_pkg::coord_t         m_clipped_end_y,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  lsc_pkg::cfg_index_t     cfg_index,
    input  lsc_pkg::coord_t         cfg_data
);
    import lsc_pkg::*;

    typedef struct packed {
        coord_t     x0;
        coord_t     y0;
        coord_t     x1;
        coord_t     y1;
        delta_t     dx;
        delta_t     dy;
        logic       in_window;
        logic [3:0] pneg;
        logic [3:0] ppos;
        logic [3:0] qneg;
    } side_t;

    typedef struct packed {
        logic   ok;
        ratio_t t0;
        ratio_t t1;
    } clip_t;

    function automatic div_lane_t div_setup(input delta_t p, input delta_t q);
        div_lane_t              lane;
        logic [COORD_WIDTH-1:0] pm;
        logic [COORD_WIDTH-1:0] qm;
        pm = p[DELTA_WIDTH-1] ? COORD_WIDTH'(-p) : COORD_WIDTH'(p);
        qm = q[DELTA_WIDTH-1] ? COORD_WIDTH'(-q) : COORD_WIDTH'(q);
        lane.mp   = pm;
        lane.frac = '0;
        lane.ip   = (qm >= pm);
        lane.sat  = ({1'b0, qm} >= {pm, 1'b0});
        lane.rem  = lane.ip ? (qm - pm) : qm;
        lane.neg  = q[DELTA_WIDTH-1] ^ p[DELTA_WIDTH-1];
        return lane;
    endfunction

    function automatic clip_t edge_test(input clip_t c, input logic pn, input logic pp,
                                        input logic qn, input ratio_t r);
        clip_t res;
        res = c;
        if (c.ok) begin
            if (pn) begin
                if (r > c.t1) begin
                    res.ok = 1'b0;
                end else if (r > c.t0) begin
                    res.t0 = r;
                end
            end else if (pp) begin
                if (r < c.t0) begin
                    res.ok = 1'b0;
                end else if (r < c.t1) begin
                    res.t1 = r;
                end
            end else if (qn) begin
                res.ok = 1'b0;
            end
        end
        return res;
    endfunction

    logic   en;
    coord_t clip_left_reg, clip_right_reg, clip_bottom_reg, clip_top_reg;

    // Front stage
    delta_t    dx, dy;
    delta_t    p_val [4];
    delta_t    q_val [4];
    side_t     front_side;
    div_lane_t lane_reg [4];
    ratio_t    ratio [4];

    side_t  side_reg  [DIV_STAGES+1];
    logic   valid_reg [DIV_STAGES+1];

    side_t  e1_side_reg, e2_side_reg;
    clip_t  e1_clip_next, e1_clip_reg, e2_clip_next, e2_clip_reg;
    ratio_t e1_rb_reg, e1_rt_reg;
    logic   e1_valid_reg, e2_valid_reg;

    side_t  mul_side_reg;
    logic   mul_ok_reg, mul_use_start_reg, mul_use_end_reg, mul_valid_reg;
    coord_t ix0, iy0, ix1, iy1;

    logic   out_valid_reg, out_visible_reg;
    coord_t out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;
    logic   clipped;

    assign en        = !out_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_left_reg   <= coord_t'(0);
            clip_right_reg  <= coord_t'(32767);
            clip_bottom_reg <= coord_t'(0);
            clip_top_reg    <= coord_t'(32767);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_data;
                REG_CLIP_RIGHT:  clip_right_reg  <= cfg_data;
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data;
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Edge order is left, right, bottom, top.
    always_comb begin
        dx = delta_t'(s_end_x) - delta_t'(s_start_x);
        dy = delta_t'(s_end_y) - delta_t'(s_start_y);
        p_val[0] = -dx;
        q_val[0] = delta_t'(s_start_x) - delta_t'(clip_left_reg);
        p_val[1] = dx;
        q_val[1] = delta_t'(clip_right_reg) - delta_t'(s_start_x);
        p_val[2] = -dy;
        q_val[2] = delta_t'(s_start_y) - delta_t'(clip_bottom_reg);
        p_val[3] = dy;
        q_val[3] = delta_t'(clip_top_reg) - delta_t'(s_start_y);
        front_side.x0 = s_start_x;
        front_side.y0 = s_start_y;
        front_side.x1 = s_end_x;
        front_side.y1 = s_end_y;
        front_side.dx = dx;
        front_side.dy = dy;
        front_side.in_window = (s_start_x >= clip_left_reg) && (s_start_x <= clip_right_reg) &&
                               (s_end_x >= clip_left_reg) && (s_end_x <= clip_right_reg) &&
                               (s_start_y >= clip_bottom_reg) && (s_start_y <= clip_top_reg) &&
                               (s_end_y >= clip_bottom_reg) && (s_end_y <= clip_top_reg);
        for (int i = 0; i < 4; i++) begin
            front_side.pneg[i] = p_val[i][DELTA_WIDTH-1];
            front_side.ppos[i] = !p_val[i][DELTA_WIDTH-1] && (p_val[i] != '0);
            front_side.qneg[i] = q_val[i][DELTA_WIDTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= front_side;
            for (int i = 0; i < 4; i++) begin
                lane_reg[i] <= div_setup(p_val[i], q_val[i]);
            end
            for (int s = 1; s <= DIV_STAGES; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                valid_reg[s] <= 1'b0;
            end
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= s_valid;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
            e1_valid_reg  <= valid_reg[DIV_STAGES];
            e2_valid_reg  <= e1_valid_reg;
            mul_valid_reg <= e2_valid_reg;
            out_valid_reg <= mul_valid_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < 4; gi++) begin : g_div
            lsc_divider u_div (
                .aclk    (aclk),
                .en      (en),
                .lane_in (lane_reg[gi]),
                .ratio   (ratio[gi])
            );
        end
    endgenerate

    // Edge tests run two to a stage.
    always_comb begin
        clip_t start;
        start.ok = 1'b1;
        start.t0 = '0;
        start.t1 = T_ONE;
        e1_clip_next = edge_test(start, side_reg[DIV_STAGES].pneg[0],
                                 side_reg[DIV_STAGES].ppos[0],
                                 side_reg[DIV_STAGES].qneg[0], ratio[0]);
        e1_clip_next = edge_test(e1_clip_next, side_reg[DIV_STAGES].pneg[1],
                                 side_reg[DIV_STAGES].ppos[1],
                                 side_reg[DIV_STAGES].qneg[1], ratio[1]);
        e2_clip_next = edge_test(e1_clip_reg, e1_side_reg.pneg[2], e1_side_reg.ppos[2],
                                 e1_side_reg.qneg[2], e1_rb_reg);
        e2_clip_next = edge_test(e2_clip_next, e1_side_reg.pneg[3], e1_side_reg.ppos[3],
                                 e1_side_reg.qneg[3], e1_rt_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_side_reg       <= side_reg[DIV_STAGES];
            e1_clip_reg       <= e1_clip_next;
            e1_rb_reg         <= ratio[2];
            e1_rt_reg         <= ratio[3];
            e2_side_reg       <= e1_side_reg;
            e2_clip_reg       <= e2_clip_next;
            mul_side_reg      <= e2_side_reg;
            mul_ok_reg        <= e2_clip_reg.ok;
            mul_use_start_reg <= (e2_clip_reg.t0 > ratio_t'(0));
            mul_use_end_reg   <= (e2_clip_reg.t1 < T_ONE);
        end
    end

    lsc_interp u_interp_x0 (
        .aclk (aclk), .en (en), .a (e2_side_reg.x0),
        .t (e2_clip_reg.t0[T_WIDTH-1:0]), .d (e2_side_reg.dx), .result (ix0)
    );
    lsc_interp u_interp_y0 (
        .aclk (aclk), .en (en), .a (e2_side_reg.y0),
        .t (e2_clip_reg.t0[T_WIDTH-1:0]), .d (e2_side_reg.dy), .result (iy0)
    );
    lsc_interp u_interp_x1 (
        .aclk (aclk), .en (en), .a (e2_side_reg.x0),
        .t (e2_clip_reg.t1[T_WIDTH-1:0]), .d (e2_side_reg.dx), .result (ix1)
    );
    lsc_interp u_interp_y1 (
        .aclk (aclk), .en (en), .a (e2_side_reg.y0),
        .t (e2_clip_reg.t1[T_WIDTH-1:0]), .d (e2_side_reg.dy), .result (iy1)
    );

    // A segment wholly inside the window skips the edge results altogether.
    assign clipped = !mul_side_reg.in_window && mul_ok_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_visible_reg <= mul_side_reg.in_window || mul_ok_reg;
            out_sx_reg <= (clipped && mul_use_start_reg) ? ix0 : mul_side_reg.x0;
            out_sy_reg <= (clipped && mul_use_start_reg) ? iy0 : mul_side_reg.y0;
            out_ex_reg <= (clipped && mul_use_end_reg) ? ix1 : mul_side_reg.x1;
            out_ey_reg <= (clipped && mul_use_end_reg) ? iy1 : mul_side_reg.y1;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_visible         = out_visible_reg;
    assign m_clipped_start_x = out_sx_reg;
    assign m_clipped_start_y = out_sy_reg;
    assign m_clipped_end_x   = out_ex_reg;
    assign m_clipped_end_y   = out_ey_reg;

endmodule

`default_nettype wire
